FILE: rtl/core/h264_rtp_fu_a_packetizer_core_defines.svh
// Assertion macros shared by the RTL of the FU-A packetizer.
`ifndef H264_RTP_FU_A_PACKETIZER_CORE_DEFINES_SVH
`define H264_RTP_FU_A_PACKETIZER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define H264FU_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

`define H264FU_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`else

`define H264FU_ASSERT_ALWAYS(label, cond, msg)

`define H264FU_ASSERT_IMPLY(label, ante, cons, msg)

`endif

`endif

FILE: rtl/core/h264fu_pkg.sv
package h264fu_pkg;

    localparam int LENGTH_BITS = 20;

    localparam int QUEUE_DEPTH = 4;
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int MAX_RESULTS = 3;
    localparam int RES_N_W     = $clog2(MAX_RESULTS + 1);

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [PADDR_W-1:0] REG_MAX_PAYLOAD_ADDR = PADDR_W'(0);

    localparam logic [4:0]  FU_A_TYPE     = 5'd28;
    localparam logic [7:0]  NAL_TYPE_MASK = 8'h1F;
    localparam logic [15:0] FU_OVERHEAD   = 16'd2;
    localparam logic [15:0] MIN_PAYLOAD   = 16'd4;
    localparam logic [15:0] PAYLOAD_RESET = 16'd1400;

    typedef struct packed {
        logic [7:0]  nal_byte;
        logic        first_byte;
        logic [19:0] nal_length;
        logic [31:0] timestamp;
        logic        mark_request;
    } in_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        packet_first;
        logic        packet_last;
        logic        marker;
        logic [31:0] packet_time;
        logic        run_end;
    } out_t;

endpackage

FILE: rtl/core/h264_rtp_fu_a_packetizer_core.sv
// H.264 RTP payload packetizer (single NAL unit and FU-A modes). NAL unit bytes enter one per
// transaction on the s_ channel, header byte first with first_byte set; the unit length,
// timestamp and marker request are taken with that header byte. Units no longer than
// max_payload (taken as 4 if lower) pass through as one packet; longer units are split into
// FU-A fragments of max_payload - 2 data bytes, each opened by an indicator and an FU header
// byte. Each payload byte leaves as one transaction on the m_ channel with packet boundary
// flags, and run_end marks the last one caused by an input transaction. Every input
// transaction is decoded in the cycle it is accepted and its results enter a four-entry output
// queue, so the input takes one byte per cycle and is held back only while the queue has more
// than one entry waiting: a fragment's opening byte yields three results, others at most one.
// max_payload is written through the APB port at address 0 and applies from the next unit.
`include "h264_rtp_fu_a_packetizer_core_defines.svh"

module h264_rtp_fu_a_packetizer_core (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  h264fu_pkg::in_t               s_data,

    output logic                          m_valid,
    input  logic                          m_ready,
    output h264fu_pkg::out_t              m_data,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [h264fu_pkg::PADDR_W-1:0] paddr,
    input  logic [h264fu_pkg::PDATA_W-1:0] pwdata,
    output logic [h264fu_pkg::PDATA_W-1:0] prdata,
    output logic                          pready
);

    import h264fu_pkg::*;

    logic [15:0]            max_payload_reg;

    logic [7:0]             header_byte_reg,    header_byte_next;
    logic [LENGTH_BITS-1:0] unit_length_reg,    unit_length_next;
    logic [LENGTH_BITS-1:0] byte_offset_reg,    byte_offset_next;
    logic                   fragmenting_reg,    fragmenting_next;
    logic [15:0]            fragment_left_reg,  fragment_left_next;
    logic                   first_fragment_reg, first_fragment_next;
    logic                   held_mark_reg,      held_mark_next;
    logic [31:0]            held_time_reg,      held_time_next;
    logic [15:0]            frag_size_reg,      frag_size_next;
    logic                   frag_end_reg,       frag_end_next;

    out_t                   slot_reg [QUEUE_DEPTH];
    out_t                   slot_next [QUEUE_DEPTH];
    logic [QCNT_W-1:0]      cnt_reg, cnt_next;

    out_t                   res [MAX_RESULTS];
    logic [RES_N_W-1:0]     res_n;

    logic [LENGTH_BITS-1:0] len_new;
    logic [15:0]            mp;
    logic [LENGTH_BITS-1:0] rem;
    logic [15:0]            size;
    logic                   active;
    logic                   mk;
    logic                   push;
    logic                   pop;
    logic                   cfg_write;
    logic [QCNT_W-1:0]      base;
    logic                   last_run_end;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr == REG_MAX_PAYLOAD_ADDR) ? PDATA_W'(max_payload_reg) : '0;

    assign s_ready = (cnt_reg <= QCNT_W'(1));
    assign m_valid = (cnt_reg != '0);
    assign m_data  = slot_reg[0];
    assign push    = s_valid && s_ready;
    assign pop     = m_valid && m_ready;

    always_comb begin
        header_byte_next    = header_byte_reg;
        unit_length_next    = unit_length_reg;
        byte_offset_next    = byte_offset_reg;
        fragmenting_next    = fragmenting_reg;
        fragment_left_next  = fragment_left_reg;
        first_fragment_next = first_fragment_reg;
        held_mark_next      = held_mark_reg;
        held_time_next      = held_time_reg;
        frag_size_next      = frag_size_reg;
        frag_end_next       = frag_end_reg;
        res_n               = '0;
        rem                 = '0;
        size                = '0;
        mk                  = 1'b0;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            res[i] = '0;
        end

        len_new = LENGTH_BITS'(s_data.nal_length);
        if (len_new == '0) begin
            len_new = LENGTH_BITS'(1);
        end
        mp = (max_payload_reg < MIN_PAYLOAD) ? MIN_PAYLOAD : max_payload_reg;

        if (s_data.first_byte) begin
            active              = 1'b1;
            unit_length_next    = len_new;
            held_time_next      = s_data.timestamp;
            held_mark_next      = s_data.mark_request;
            header_byte_next    = s_data.nal_byte;
            byte_offset_next    = '0;
            fragmenting_next    = (len_new > LENGTH_BITS'(mp));
            frag_size_next      = mp - FU_OVERHEAD;
            fragment_left_next  = '0;
            first_fragment_next = 1'b1;
            frag_end_next       = 1'b0;
        end else begin
            active = (byte_offset_reg < unit_length_reg);
        end

        if (active) begin
            if (!fragmenting_next) begin
                res[0].payload_byte = s_data.nal_byte;
                res[0].packet_first = (byte_offset_next == '0);
                res[0].packet_last  = (byte_offset_next == unit_length_next - LENGTH_BITS'(1));
                res[0].marker       = held_mark_next;
                res[0].packet_time  = held_time_next;
                res_n               = RES_N_W'(1);
            end else if (byte_offset_next != '0) begin
                if (fragment_left_next == '0) begin
                    rem = unit_length_next - byte_offset_next;
                    if (first_fragment_next) begin
                        size          = frag_size_next;
                        frag_end_next = 1'b0;
                    end else if (rem <= LENGTH_BITS'(frag_size_next)) begin
                        size          = rem[15:0];
                        frag_end_next = 1'b1;
                    end else begin
                        size          = frag_size_next;
                        frag_end_next = 1'b0;
                    end
                    mk = held_mark_next && frag_end_next;
                    res[0].payload_byte = {header_byte_next[7:5], FU_A_TYPE};
                    res[0].packet_first = 1'b1;
                    res[0].marker       = mk;
                    res[0].packet_time  = held_time_next;
                    res[1].payload_byte = {first_fragment_next, frag_end_next, 1'b0,
                                           header_byte_next[4:0] & NAL_TYPE_MASK[4:0]};
                    res[1].marker       = mk;
                    res[1].packet_time  = held_time_next;
                    res_n               = RES_N_W'(2);
                    fragment_left_next  = size;
                    first_fragment_next = 1'b0;
                end
                mk = held_mark_next && frag_end_next;
                res[res_n[1:0]].payload_byte = s_data.nal_byte;
                res[res_n[1:0]].packet_last  = (fragment_left_next == 16'd1);
                res[res_n[1:0]].marker       = mk;
                res[res_n[1:0]].packet_time  = held_time_next;
                res_n                        = res_n + RES_N_W'(1);
                fragment_left_next           = fragment_left_next - 16'd1;
            end
            byte_offset_next = byte_offset_next + LENGTH_BITS'(1);
        end

        for (int i = 0; i < MAX_RESULTS; i++) begin
            res[i].run_end = (RES_N_W'(i + 1) == res_n);
        end
    end

    always_comb begin
        base = cnt_reg - QCNT_W'(pop);
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (pop && (i < QUEUE_DEPTH - 1)) begin
                slot_next[i] = slot_reg[(i + 1) % QUEUE_DEPTH];
            end else begin
                slot_next[i] = slot_reg[i];
            end
            for (int j = 0; j < MAX_RESULTS; j++) begin
                if (push && (RES_N_W'(j) < res_n) && (QCNT_W'(i) == base + QCNT_W'(j))) begin
                    slot_next[i] = res[j];
                end
            end
        end
        cnt_next = base + (push ? QCNT_W'(res_n) : '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_reg    <= PAYLOAD_RESET;
            header_byte_reg    <= '0;
            unit_length_reg    <= '0;
            byte_offset_reg    <= '0;
            fragmenting_reg    <= 1'b0;
            fragment_left_reg  <= '0;
            first_fragment_reg <= 1'b0;
            held_mark_reg      <= 1'b0;
            held_time_reg      <= '0;
            frag_size_reg      <= '0;
            frag_end_reg       <= 1'b0;
            cnt_reg            <= '0;
        end else begin
            if (cfg_write && (paddr == REG_MAX_PAYLOAD_ADDR)) begin
                max_payload_reg <= pwdata[15:0];
            end
            if (push) begin
                header_byte_reg    <= header_byte_next;
                unit_length_reg    <= unit_length_next;
                byte_offset_reg    <= byte_offset_next;
                fragmenting_reg    <= fragmenting_next;
                fragment_left_reg  <= fragment_left_next;
                first_fragment_reg <= first_fragment_next;
                held_mark_reg      <= held_mark_next;
                held_time_reg      <= held_time_next;
                frag_size_reg      <= frag_size_next;
                frag_end_reg       <= frag_end_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            slot_reg[i] <= slot_next[i];
        end
    end

    assign last_run_end = slot_reg[QIDX_W'(cnt_reg - QCNT_W'(1))].run_end;

    `H264FU_ASSERT_ALWAYS(a_queue_bound, cnt_reg <= QCNT_W'(QUEUE_DEPTH), "Output queue overflow.")
    `H264FU_ASSERT_IMPLY(a_tail_run_end, cnt_reg != '0, last_run_end, "Queue tail lacks run_end.")
    `H264FU_ASSERT_IMPLY(a_frag_left, fragmenting_reg, fragment_left_reg <= frag_size_reg,
                         "Fragment byte count exceeds the fragment size.")

endmodule

FILE: sim/tb.sv
module tb;
    import h264fu_pkg::*;

    typedef struct {
        int          new_max;
        in_t         item;
        int          n;
        logic [23:0] bytes;
        bit          f;
        bit          l;
        bit          m;
    } stim_row_t;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    in_t                 s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    out_t                m_data;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [PDATA_W-1:0]  pwdata  = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // Copy of the block's register and unit state, advanced on every accepted byte.
    logic [15:0] cfg_max_payload = PAYLOAD_RESET;
    logic [7:0]  p_header     = '0;
    logic [19:0] p_length     = '0;
    logic [19:0] p_offset     = '0;
    logic        p_fu_mode    = 1'b0;
    logic [15:0] p_frag_left  = '0;
    logic        p_first_frag = 1'b0;
    logic        p_mark       = 1'b0;
    logic [31:0] p_time       = '0;
    logic [15:0] p_frag_size  = '0;
    logic        p_end_bit    = 1'b0;

    out_t        pred_buf[3];
    out_t        payload_due[$];
    in_t         unit_q[$];
    in_t         carry_q[$];
    stim_row_t   dir_q[$];
    stim_row_t   cur_row;

    bit calm = 1'b0;
    int err_count = 0;
    int n_checked = 0;
    int n_units = 0;
    int n_frag_units = 0;
    int n_settings = 0;
    int payload_limits[10] = '{3, 4, 5, 6, 9, 17, 40, 65535, 4, 7};

    h264_rtp_fu_a_packetizer_core uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic out_t make_res(input logic [7:0] b, input logic f, input logic l,
                                      input logic m);
        out_t r;
        r.payload_byte = b;
        r.packet_first = f;
        r.packet_last  = l;
        r.marker       = m;
        r.packet_time  = p_time;
        r.run_end      = 1'b0;
        return r;
    endfunction

    // Advances the unit state by one NAL byte and leaves its payload bytes in pred_buf.
    function automatic int packetize_byte(input in_t it);
        int          n;
        logic [19:0] len;
        logic [19:0] rem;
        logic [15:0] mp;
        logic [15:0] size;
        n = 0;
        if (it.first_byte) begin
            len = it.nal_length;
            mp = (cfg_max_payload < MIN_PAYLOAD) ? MIN_PAYLOAD : cfg_max_payload;
            if (len == 0) begin
                len = 20'd1;
            end
            p_length     = len;
            p_time       = it.timestamp;
            p_mark       = it.mark_request;
            p_header     = it.nal_byte;
            p_offset     = '0;
            p_fu_mode    = (len > 20'(mp));
            p_frag_size  = mp - FU_OVERHEAD;
            p_frag_left  = '0;
            p_first_frag = 1'b1;
            p_end_bit    = 1'b0;
        end else if (p_offset >= p_length) begin
            return 0;
        end
        if (!p_fu_mode) begin
            pred_buf[n] = make_res(it.nal_byte, p_offset == 0, p_offset == p_length - 1, p_mark);
            n++;
        end else if (p_offset != 0) begin
            if (p_frag_left == 0) begin
                rem = p_length - p_offset;
                if (p_first_frag) begin
                    size = p_frag_size;
                    p_end_bit = 1'b0;
                end else if (rem <= 20'(p_frag_size)) begin
                    size = rem[15:0];
                    p_end_bit = 1'b1;
                end else begin
                    size = p_frag_size;
                    p_end_bit = 1'b0;
                end
                pred_buf[n] = make_res({p_header[7:5], FU_A_TYPE}, 1'b1, 1'b0,
                                       p_mark & p_end_bit);
                n++;
                pred_buf[n] = make_res((p_header & NAL_TYPE_MASK) |
                                       {p_first_frag, p_end_bit, 6'b0},
                                       1'b0, 1'b0, p_mark & p_end_bit);
                n++;
                p_frag_left  = size;
                p_first_frag = 1'b0;
            end
            pred_buf[n] = make_res(it.nal_byte, 1'b0, p_frag_left == 1, p_mark & p_end_bit);
            n++;
            p_frag_left = p_frag_left - 16'd1;
        end
        p_offset = p_offset + 20'd1;
        if (n > 0) begin
            pred_buf[n-1].run_end = 1'b1;
        end
        return n;
    endfunction

    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= 10) begin
            $display("%s", msg);
        end
    endtask

    always @(posedge aclk) begin : monitor
        int   n;
        out_t got;
        out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                n = packetize_byte(s_data);
                if (s_data.first_byte) begin
                    n_units++;
                    if (p_fu_mode) begin
                        n_frag_units++;
                    end
                end
                if (cur_row.n >= 0) begin
                    n = cur_row.n;
                    for (int k = 0; k < n; k++) begin
                        pred_buf[k] = make_res(cur_row.bytes[8*(n-1-k) +: 8],
                                               (k == 0) ? cur_row.f : 1'b0,
                                               (k == n - 1) ? cur_row.l : 1'b0, cur_row.m);
                        pred_buf[k].run_end = (k == n - 1);
                    end
                end
                for (int k = 0; k < n; k++) begin
                    payload_due.push_back(pred_buf[k]);
                end
            end
            if (m_valid && m_ready) begin
                got = m_data;
                if (payload_due.size() == 0) begin
                    flag_error($sformatf("unexpected result: byte %02h", got.payload_byte));
                end else begin
                    want = payload_due.pop_front();
                    if (got.payload_byte !== want.payload_byte ||
                        got.packet_first !== want.packet_first ||
                        got.packet_last !== want.packet_last ||
                        got.marker !== want.marker ||
                        got.packet_time !== want.packet_time ||
                        got.run_end !== want.run_end) begin
                        flag_error({$sformatf("result %0d: want b=%02h f=%b l=%b m=%b t=%h e=%b",
                                              n_checked, want.payload_byte, want.packet_first,
                                              want.packet_last, want.marker, want.packet_time,
                                              want.run_end),
                                    $sformatf(" got b=%02h f=%b l=%b m=%b t=%h e=%b",
                                              got.payload_byte, got.packet_first,
                                              got.packet_last, got.marker, got.packet_time,
                                              got.run_end)});
                    end
                end
                n_checked++;
            end
        end
    end

    initial begin : sink_side
        int stall;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            @(negedge aclk);
        end
    end

    task automatic send_item(input in_t it);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (payload_due.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic apb_xfer(input bit wr, input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= REG_MAX_PAYLOAD_ADDR;
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    // The previous setting is read back before each new one is written.
    task automatic program_max(input int val);
        logic [31:0] rd;
        drain();
        apb_xfer(1'b0, '0, rd);
        if (rd[15:0] !== cfg_max_payload) begin
            flag_error($sformatf("max_payload read %0d, want %0d", rd[15:0], cfg_max_payload));
        end
        apb_xfer(1'b1, {16'($urandom), 16'(val)}, rd);
        cfg_max_payload = 16'(val);
        n_settings++;
    endtask

    function automatic in_t noise_item();
        in_t it;
        it.nal_byte     = 8'($urandom);
        it.first_byte   = 1'b0;
        it.nal_length   = 20'($urandom);
        it.timestamp    = $urandom;
        it.mark_request = 1'($urandom);
        return it;
    endfunction

    function automatic stim_row_t stim_row(input int new_max, input logic [7:0] b,
                                           input logic fb, input logic [19:0] len,
                                           input logic [31:0] ts, input logic mk, input int n,
                                           input logic [23:0] bytes, input bit f, input bit l,
                                           input bit m);
        stim_row_t r;
        r.new_max           = new_max;
        r.item.nal_byte     = b;
        r.item.first_byte   = fb;
        r.item.nal_length   = len;
        r.item.timestamp    = ts;
        r.item.mark_request = mk;
        r.n                 = n;
        r.bytes             = bytes;
        r.f                 = f;
        r.l                 = l;
        r.m                 = m;
        return r;
    endfunction

    task automatic build_unit();
        int  eff;
        int  kind;
        int  len;
        int  body;
        int  top;
        in_t it;
        eff  = (cfg_max_payload < MIN_PAYLOAD) ? MIN_PAYLOAD : cfg_max_payload;
        kind = $urandom_range(0, 19);
        top  = (eff <= 20) ? 3 * eff + 4 : 60;
        len  = $urandom_range(1, top);
        if (eff <= 60 && $urandom_range(0, 3) == 0) begin
            len = eff + $urandom_range(0, 1);
        end
        if (kind < 2) begin
            len = 0;
        end
        if (kind >= 2 && kind < 4) begin
            len  = $urandom & 32'hF_FFFF;
            body = $urandom_range(0, 5);
        end else begin
            body = (len > 1) ? len - 1 : 0;
        end
        it.nal_byte     = 8'($urandom);
        it.first_byte   = 1'b1;
        it.nal_length   = 20'(len);
        it.timestamp    = $urandom;
        it.mark_request = 1'($urandom);
        unit_q.push_back(it);
        repeat (body) unit_q.push_back(noise_item());
    endtask

    initial begin : stimulus
        int i;
        int p;
        int cut;
        int phase_items;
        int total_items;
        int w;
        cur_row.n = -1;
        dir_q.push_back(stim_row(-1, 8'hFF, 1, 20'd1, 32'hFFFF_FFFF, 1, 1, 24'hFF, 1, 1, 1));
        dir_q.push_back(stim_row(-1, 8'h00, 0, 20'd9, 32'h0, 0, 0, 24'h0, 0, 0, 0));
        dir_q.push_back(stim_row(-1, 8'h00, 1, 20'd0, 32'h0, 0, 1, 24'h00, 1, 1, 0));
        dir_q.push_back(stim_row(-1, 8'h65, 1, 20'd3, 32'h1234_5678, 1, 1, 24'h65, 1, 0, 1));
        dir_q.push_back(stim_row(-1, 8'h80, 0, 20'd0, 32'h0, 0, 1, 24'h80, 0, 0, 1));
        dir_q.push_back(stim_row(-1, 8'h7F, 0, 20'd0, 32'h0, 0, 1, 24'h7F, 0, 1, 1));
        dir_q.push_back(stim_row(-1, 8'h55, 0, 20'hF_FFFF, 32'hFFFF_FFFF, 1, 0, 24'h0, 0, 0, 0));
        dir_q.push_back(stim_row(-1, 8'h41, 1, 20'hF_FFFF, 32'hA5A5_5A5A, 1, 0, 24'h0, 0, 0, 0));
        dir_q.push_back(stim_row(-1, 8'hAA, 0, 20'd0, 32'h0, 0, 3, 24'h5C81AA, 1, 0, 0));
        dir_q.push_back(stim_row(-1, 8'h3C, 0, 20'd0, 32'h0, 0, 1, 24'h3C, 0, 0, 0));
        dir_q.push_back(stim_row(-1, 8'h09, 1, 20'd3, 32'h0BAD_F00D, 0, 1, 24'h09, 1, 0, 0));
        dir_q.push_back(stim_row(-1, 8'hFF, 0, 20'd0, 32'h0, 0, 1, 24'hFF, 0, 0, 0));
        dir_q.push_back(stim_row(4, 8'h11, 0, 20'd0, 32'h0, 0, 1, 24'h11, 0, 1, 0));
        dir_q.push_back(stim_row(-1, 8'hE7, 1, 20'd7, 32'h7777_0000, 1, 0, 24'h0, 0, 0, 0));
        dir_q.push_back(stim_row(-1, 8'h01, 0, 20'd0, 32'h0, 0, 3, 24'hFC8701, 1, 0, 0));
        dir_q.push_back(stim_row(-1, 8'h02, 0, 20'd0, 32'h0, 0, 1, 24'h02, 0, 1, 0));
        dir_q.push_back(stim_row(-1, 8'h03, 0, 20'd0, 32'h0, 0, 3, 24'hFC0703, 1, 0, 0));
        dir_q.push_back(stim_row(-1, 8'h04, 0, 20'd0, 32'h0, 0, 1, 24'h04, 0, 1, 0));
        dir_q.push_back(stim_row(-1, 8'h05, 0, 20'd0, 32'h0, 0, 3, 24'hFC4705, 1, 0, 1));
        dir_q.push_back(stim_row(-1, 8'h06, 0, 20'd0, 32'h0, 0, 1, 24'h06, 0, 1, 1));
        dir_q.push_back(stim_row(-1, 8'h77, 0, 20'd5, 32'h0, 1, 0, 24'h0, 0, 0, 0));
        dir_q.push_back(stim_row(3, 8'h3A, 1, 20'd5, 32'h0000_0001, 0, 0, 24'h0, 0, 0, 0));
        dir_q.push_back(stim_row(-1, 8'h01, 0, 20'd0, 32'h0, 0, -1, 24'h0, 0, 0, 0));
        dir_q.push_back(stim_row(-1, 8'h02, 0, 20'd0, 32'h0, 0, -1, 24'h0, 0, 0, 0));

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        total_items = 0;
        for (i = 0; i < dir_q.size(); i++) begin
            if (dir_q[i].new_max >= 0) begin
                program_max(dir_q[i].new_max);
            end
            cur_row = dir_q[i];
            send_item(dir_q[i].item);
            total_items++;
        end
        cur_row.n = -1;

        // The last unit of each phase but the last may be cut short, so the setting can change while it is open.
        for (p = 0; p < 10; p++) begin
            program_max(payload_limits[p]);
            calm = ($urandom_range(0, 3) == 0);
            while (carry_q.size() != 0) begin
                send_item(carry_q.pop_front());
            end
            phase_items = 0;
            while (phase_items < 25) begin
                unit_q.delete();
                build_unit();
                phase_items += unit_q.size();
                if ($urandom_range(0, 7) == 0) begin
                    repeat ($urandom_range(1, 2)) unit_q.push_back(noise_item());
                end
                total_items += unit_q.size();
                cut = unit_q.size();
                if (phase_items >= 25 && p < 9) begin
                    cut = $urandom_range(1, unit_q.size());
                end
                for (i = 0; i < unit_q.size(); i++) begin
                    if (i < cut) begin
                        send_item(unit_q[i]);
                    end else begin
                        carry_q.push_back(unit_q[i]);
                    end
                end
                if ($urandom_range(0, 14) == 0) begin
                    drain();
                end
            end
        end

        s_valid <= 1'b0;
        w = 0;
        while (payload_due.size() != 0 && w < 5000) begin
            @(negedge aclk);
            w++;
        end
        if (payload_due.size() != 0) begin
            flag_error($sformatf("%0d expected results never arrived", payload_due.size()));
        end
        repeat (20) @(negedge aclk);

        $display("Sent %0d NAL byte transactions in %0d units, %0d of them split into FU-A.",
                 total_items, n_units, n_frag_units);
        $display("Checked %0d payload byte transactions over %0d max_payload settings.",
                 n_checked, n_settings);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

FILE: h264_rtp_fu_a_packetizer_core.f
+incdir+rtl/core
rtl/core/h264fu_pkg.sv
rtl/core/h264_rtp_fu_a_packetizer_core.sv
sim/tb.sv
